### hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules of the nucleotide dictionary; only the top level uses them.
// Each macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hw/rtl/dnadh_pkg.sv
// Package for the nucleotide dictionary: table geometry, entry layout, result codes
// and the structs between the top level and the hash unit. No dependencies.
package dnadh_pkg;

   localparam int TABLE_SIZE = 8191;
   localparam int MAX_LENGTH = 12;
   localparam int FIELD_SYMBOLS = 12;
   localparam int LEN_CAP = (MAX_LENGTH < FIELD_SYMBOLS) ? MAX_LENGTH : FIELD_SYMBOLS;

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam int SYM_W = 2 * FIELD_SYMBOLS;
   localparam int LEN_W = 4;
   localparam int IDX_W = $clog2(FIELD_SYMBOLS);
   localparam int ENTRY_W = 1 + LEN_W + SYM_W;
   localparam int PROBE_W = 13;

   typedef logic [FIELD_SYMBOLS-1:0][1:0] sym_array_type;

   typedef struct packed {
      logic               valid;
      logic [LEN_W-1:0]   len;
      sym_array_type      syms;
   } entry_type;

   typedef enum logic [1:0] {
      RES_PRESENT  = 2'd0,
      RES_ABSENT   = 2'd1,
      RES_INSERTED = 2'd2,
      RES_FULL     = 2'd3
   } result_code_type;

   localparam logic ACT_FIND   = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef struct packed {
      logic               start;
      sym_array_type      syms;
      logic [LEN_W-1:0]   len;
   } hash_req_type;

   typedef struct packed {
      logic               done;
      logic [ADDR_W-1:0]  home;
      logic [ADDR_W-1:0]  step;
   } hash_res_type;

endpackage

### hw/rtl/dnadh_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the dictionary table.
module dnadh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dnadh_hash.sv
// Hash unit: folds the base-5 key one symbol per cycle, most significant first, and keeps
// its residues modulo TABLE_SIZE and TABLE_SIZE-1. Depends on dnadh_pkg.
module dnadh_hash
   import dnadh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_req_type req,
   output hash_res_type res
);

   localparam int TW = ADDR_W + 3;
   localparam logic [TW-1:0] M1 = TW'(TABLE_SIZE);
   localparam logic [TW-1:0] M2 = TW'(2 * TABLE_SIZE);
   localparam logic [TW-1:0] M3 = TW'(3 * TABLE_SIZE);
   localparam logic [TW-1:0] M4 = TW'(4 * TABLE_SIZE);
   localparam logic [TW-1:0] N1 = TW'(TABLE_SIZE - 1);
   localparam logic [TW-1:0] N2 = TW'(2 * (TABLE_SIZE - 1));
   localparam logic [TW-1:0] N3 = TW'(3 * (TABLE_SIZE - 1));
   localparam logic [TW-1:0] N4 = TW'(4 * (TABLE_SIZE - 1));

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   sym_array_type       syms_ff, syms_in;
   logic [ADDR_W-1:0]   r1_ff, r1_in;
   logic [ADDR_W-1:0]   r2_ff, r2_in;

   logic [2:0]          digit;
   logic [TW-1:0]       t1, t2, u1, u2;

   // Symbol codes 0..3 count as digits 1..4.
   assign digit = {1'b0, syms_ff[idx_ff]} + 3'd1;
   assign t1 = {1'b0, r1_ff, 2'b00} + {3'b000, r1_ff} + {{(TW-3){1'b0}}, digit};
   assign t2 = {1'b0, r2_ff, 2'b00} + {3'b000, r2_ff} + {{(TW-3){1'b0}}, digit};

   // 5r + d stays below five times the modulus, so four compares finish the reduction.
   always_comb begin
      priority if (t1 >= M4) u1 = t1 - M4;
      else if (t1 >= M3) u1 = t1 - M3;
      else if (t1 >= M2) u1 = t1 - M2;
      else if (t1 >= M1) u1 = t1 - M1;
      else u1 = t1;
      priority if (t2 >= N4) u2 = t2 - N4;
      else if (t2 >= N3) u2 = t2 - N3;
      else if (t2 >= N2) u2 = t2 - N2;
      else if (t2 >= N1) u2 = t2 - N1;
      else u2 = t2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      syms_in = syms_ff;
      r1_in   = r1_ff;
      r2_in   = r2_ff;
      if (req.start) begin
         busy_in = 1'b1;
         syms_in = req.syms;
         idx_in  = IDX_W'(req.len - LEN_W'(1));
         r1_in   = '0;
         r2_in   = '0;
      end else if (busy_ff) begin
         r1_in = ADDR_W'(u1);
         r2_in = ADDR_W'(u2);
         idx_in = idx_ff - IDX_W'(1);
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff  <= idx_in;
      syms_ff <= syms_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
   end

   assign res.done = done_ff;
   assign res.home = r1_ff;
   assign res.step = r2_ff + ADDR_W'(1);

endmodule

### hw/rtl/dna_dictionary_double_hash_top.sv
// Nucleotide string dictionary in an open-addressed table with double hashing.
// Depends on dnadh_pkg, dnadh_hash, dnadh_ram and assert_macros.svh.
`include "assert_macros.svh"

// After reset the block clears every entry of the table memory and holds req_ready low
// meanwhile. One item is worked at a time. The hash unit folds one base-5 digit per
// cycle, and the probe walk examines one slot per cycle through the registered read
// port of the table memory, issuing the next slot's read while the current entry is
// compared. A finished result sits in the response register, so the next item is
// accepted while the previous result still waits to be taken. Result codes: 0 present,
// 1 absent, 2 inserted, 3 table full after TABLE_SIZE probes.
module dna_dictionary_double_hash_top
   import dnadh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [SYM_W-1:0]     req_symbols,
   input  logic [LEN_W-1:0]     req_length,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_result_code,
   output logic [PROBE_W-1:0]   rsp_probe_count
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_LOOKUP, ST_PROBE, ST_FINISH
   } state_type;

   localparam logic [ADDR_W:0]   TS_WIDE = (ADDR_W + 1)'(TABLE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]  TS_CNT = CNT_W'(TABLE_SIZE);

   state_type              state_ff, state_in;
   logic                   insert_ff, insert_in;
   entry_type              want_ff, want_in;
   logic [ADDR_W-1:0]      slot_ff, slot_in;
   logic [ADDR_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   result_code_type        code_ff, code_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_code_type        rsp_code_ff, rsp_code_in;
   logic [PROBE_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic [LEN_W-1:0]       eff_len;
   sym_array_type          in_syms, masked_syms;
   hash_req_type           hash_req;
   hash_res_type           hash_res;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   entry_type              wr_data, rd_entry;
   logic [ENTRY_W-1:0]     rd_data;
   logic [ADDR_W:0]        slot_sum;
   logic [ADDR_W-1:0]      next_slot;
   logic                   hit, empty, last_probe;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   // A zero length counts as one symbol, and long lengths saturate.
   always_comb begin
      priority if (req_length == '0) eff_len = LEN_W'(1);
      else if (req_length > LEN_W'(LEN_CAP)) eff_len = LEN_W'(LEN_CAP);
      else eff_len = req_length;
   end

   assign in_syms = req_symbols;
   always_comb begin
      for (int i = 0; i < FIELD_SYMBOLS; i++) begin
         masked_syms[i] = (LEN_W'(i) < eff_len) ? in_syms[i] : 2'b00;
      end
   end

   assign hash_req.start = accept;
   assign hash_req.syms  = masked_syms;
   assign hash_req.len   = eff_len;

   dnadh_hash u_hash (
      .clock (clock),
      .reset (reset),
      .req   (hash_req),
      .res   (hash_res)
   );

   assign slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
   assign next_slot = (slot_sum >= TS_WIDE) ? ADDR_W'(slot_sum - TS_WIDE)
                                            : ADDR_W'(slot_sum);

   // In the probe state the read for the following slot goes out speculatively.
   assign rd_addr = (state_ff == ST_PROBE) ? next_slot : slot_ff;
   assign rd_entry = rd_data;

   assign hit = (rd_entry == want_ff);
   assign empty = !rd_entry.valid;
   assign last_probe = (count_ff + CNT_W'(1)) == TS_CNT;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = want_ff;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_data = '0;
      end else if (state_ff == ST_PROBE && !hit && empty && insert_ff) begin
         wr_en = 1'b1;
      end
   end

   // An insert never meets a read on one entry: the next item passes through the hash
   // state before its first read, well after the insert has been written.
   dnadh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      insert_in    = insert_ff;
      want_in      = want_ff;
      slot_in      = slot_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_count_in = rsp_count_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            slot_in = slot_ff + ADDR_W'(1);
            if (slot_ff == LAST_ADDR) begin
               slot_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               insert_in     = (req_action == ACT_INSERT);
               want_in.valid = 1'b1;
               want_in.len   = eff_len;
               want_in.syms  = masked_syms;
               state_in      = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_res.done) begin
               slot_in  = hash_res.home;
               step_in  = hash_res.step;
               count_in = '0;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            count_in = count_ff + CNT_W'(1);
            priority if (hit) begin
               code_in  = RES_PRESENT;
               state_in = ST_FINISH;
            end else if (empty) begin
               code_in  = insert_ff ? RES_INSERTED : RES_ABSENT;
               state_in = ST_FINISH;
            end else if (last_probe) begin
               code_in  = RES_FULL;
               state_in = ST_FINISH;
            end else begin
               slot_in = next_slot;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_count_in = PROBE_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      insert_ff    <= insert_in;
      want_ff      <= want_in;
      step_ff      <= step_in;
      count_ff     <= count_in;
      code_ff      <= code_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_probe_count = rsp_count_ff;

   `ASSERT_IMPLIES(a_slot_in_range, state_ff == ST_PROBE, slot_ff <= LAST_ADDR, "slot out of range")
   `ASSERT_IMPLIES(a_insert_into_empty, wr_en && state_ff == ST_PROBE, empty && !hit, "insert over a live entry")
   `ASSERT_IMPLIES(a_probe_bound, state_ff == ST_PROBE, count_ff < TS_CNT, "probe count past table size")
   `ASSERT_IMPLIES(a_hash_done_in_hash, hash_res.done, state_ff == ST_HASH, "hash result outside hash state")

endmodule

### dv/dna_dictionary_double_hash_top_tb.sv
// Self-checking testbench for the double-hashed nucleotide dictionary.
// Predicts each lookup with its own mirror of the table; depends on dnadh_pkg and the top level.
`timescale 1ns / 1ps

module dna_dictionary_double_hash_top_tb;
   import dnadh_pkg::*;

   localparam int RANDOM_ITEMS = 1128;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      result_code_type     code;
      logic [PROBE_W-1:0]  probes;
   } lookup_outcome_type;

   typedef struct packed {
      logic [SYM_W-1:0]  syms;
      logic [LEN_W-1:0]  len;
   } stored_string_type;

   typedef struct packed {
      logic                act;
      logic [SYM_W-1:0]    syms;
      logic [LEN_W-1:0]    len;
      logic                typed;
      result_code_type     code;
      logic [PROBE_W-1:0]  probes;
   } directed_row_type;

   // Rows with typed set carry an outcome that is plain from an empty table.
   localparam directed_row_type DIRECTED_ROWS [22] = '{
      '{ACT_FIND,   24'h000000, 4'd1,  1'b1, RES_ABSENT,   13'd1},
      '{ACT_INSERT, 24'h000000, 4'd1,  1'b1, RES_INSERTED, 13'd1},
      '{ACT_FIND,   24'h000000, 4'd1,  1'b1, RES_PRESENT,  13'd1},
      '{ACT_INSERT, 24'h000000, 4'd1,  1'b1, RES_PRESENT,  13'd1},
      '{ACT_FIND,   24'h000000, 4'd0,  1'b1, RES_PRESENT,  13'd1},
      '{ACT_FIND,   24'hFFFFFC, 4'd0,  1'b1, RES_PRESENT,  13'd1},
      '{ACT_FIND,   24'h000001, 4'd1,  1'b1, RES_ABSENT,   13'd1},
      '{ACT_INSERT, 24'h000001, 4'd1,  1'b1, RES_INSERTED, 13'd1},
      '{ACT_FIND,   24'hFFFFFD, 4'd1,  1'b1, RES_PRESENT,  13'd1},
      '{ACT_INSERT, 24'hFFFFFF, 4'd1,  1'b1, RES_INSERTED, 13'd1},
      '{ACT_FIND,   24'h000000, 4'd2,  1'b1, RES_ABSENT,   13'd1},
      '{ACT_INSERT, 24'hFFFFFF, 4'd12, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_FIND,   24'hFFFFFF, 4'd12, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_INSERT, 24'hFFFFFF, 4'd15, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_FIND,   24'hFFFFFF, 4'd13, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_INSERT, 24'h000000, 4'd12, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_FIND,   24'h000000, 4'd14, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_INSERT, 24'hAAAAAA, 4'd12, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_INSERT, 24'h555555, 4'd12, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_FIND,   24'h0000E4, 4'd6,  1'b0, RES_PRESENT,  13'd0},
      '{ACT_INSERT, 24'h9A3C51, 4'd11, 1'b0, RES_PRESENT,  13'd0},
      '{ACT_FIND,   24'hDA3C51, 4'd11, 1'b0, RES_PRESENT,  13'd0}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [SYM_W-1:0]    req_symbols;
   logic [LEN_W-1:0]    req_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_result_code;
   logic [PROBE_W-1:0]  rsp_probe_count;

   logic [ENTRY_W-1:0]  dict_table [TABLE_SIZE];
   lookup_outcome_type  lookup_outcomes_q [$];
   stored_string_type   stored_strings [$];
   int unsigned         stored_count;
   int unsigned         items_sent;
   int unsigned         results_checked;
   int unsigned         fail_count;
   int unsigned         codes_seen [4];
   int unsigned         req_idle_pct;
   int unsigned         rsp_idle_pct;
   bit                  rsp_hold_request;

   dna_dictionary_double_hash_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_symbols     (req_symbols),
      .req_length      (req_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_code (rsp_result_code),
      .rsp_probe_count (rsp_probe_count)
   );

   always #5 clock = ~clock;

   function automatic int unsigned effective_length(input logic [LEN_W-1:0] len);
      int unsigned n;
      n = (len == 0) ? 1 : len;
      if (n > LEN_CAP) n = LEN_CAP;
      return n;
   endfunction

   function automatic logic [SYM_W-1:0] symbol_mask(input int unsigned n);
      return SYM_W'((32'd1 << (2 * n)) - 1);
   endfunction

   // Walks the double-hash probe sequence over the mirror table, storing on insert.
   function automatic void walk_probe_sequence(input logic act, input logic [SYM_W-1:0] syms,
                                               input logic [LEN_W-1:0] len,
                                               output result_code_type code,
                                               output logic [PROBE_W-1:0] probes);
      int unsigned n, key, weight, slot, stride;
      logic [SYM_W-1:0] kept;
      logic [ENTRY_W-1:0] want;
      n = effective_length(len);
      kept = syms & symbol_mask(n);
      want = {1'b1, LEN_W'(n), kept};
      key = 0;
      weight = 1;
      for (int i = 0; i < n; i++) begin
         key += weight * (32'(kept[2*i +: 2]) + 1);
         weight *= 5;
      end
      slot = key % TABLE_SIZE;
      stride = 1 + key % (TABLE_SIZE - 1);
      if (stride >= TABLE_SIZE) stride %= TABLE_SIZE;
      code = RES_FULL;
      probes = PROBE_W'(TABLE_SIZE);
      for (int k = 0; k < TABLE_SIZE; k++) begin
         probes = PROBE_W'(k + 1);
         if (dict_table[slot] == want) begin
            code = RES_PRESENT;
            break;
         end
         if (!dict_table[slot][ENTRY_W-1]) begin
            if (act == ACT_INSERT) begin
               dict_table[slot] = want;
               stored_count++;
               code = RES_INSERTED;
            end else begin
               code = RES_ABSENT;
            end
            break;
         end
         slot += stride;
         if (slot >= TABLE_SIZE) slot -= TABLE_SIZE;
      end
   endfunction

   // Offers one item, and once it is taken records the outcome the block must return.
   task automatic send_item(input logic act, input logic [SYM_W-1:0] syms,
                            input logic [LEN_W-1:0] len, input logic typed,
                            input result_code_type typed_code,
                            input logic [PROBE_W-1:0] typed_probes);
      lookup_outcome_type outcome;
      int unsigned n;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_symbols <= syms;
      req_length  <= len;
      do @(posedge clock); while (!req_ready);
      walk_probe_sequence(act, syms, len, outcome.code, outcome.probes);
      if (outcome.code == RES_INSERTED) begin
         n = effective_length(len);
         stored_strings.push_back('{syms & symbol_mask(n), LEN_W'(n)});
      end
      if (typed) begin
         outcome.code = typed_code;
         outcome.probes = typed_probes;
      end
      lookup_outcomes_q.push_back(outcome);
      items_sent++;
   endtask

   task automatic send_random_item();
      stored_string_type pick;
      logic [SYM_W-1:0] syms;
      logic [LEN_W-1:0] len;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      syms = SYM_W'($urandom());
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 15))
                                        : LEN_W'($urandom_range(1, 12));
      if (roll < 40 || stored_strings.size() == 0) begin
         // New string, or a find that is most likely absent.
         send_item((roll < 25) ? ACT_INSERT : ACT_FIND, syms, len, 1'b0, RES_PRESENT, '0);
      end else begin
         // Reuse a stored string with fresh junk above its length.
         pick = stored_strings[$urandom_range(0, stored_strings.size() - 1)];
         syms = (syms & ~symbol_mask(pick.len)) | pick.syms;
         len = pick.len;
         if (len == LEN_CAP && $urandom_range(0, 3) == 0) len = LEN_W'($urandom_range(13, 15));
         if (len == 1 && $urandom_range(0, 1) == 0) len = '0;
         send_item((roll < 80) ? ACT_FIND : ACT_INSERT, syms, len, 1'b0, RES_PRESENT, '0);
      end
   endtask

   // Result side: random back-pressure, one long hold on request, and in-order checking.
   initial begin
      int unsigned hold_left;
      lookup_outcome_type want;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (lookup_outcomes_q.size() == 0) begin
               $error("result with no item waiting: result_code %0d probe_count %0d",
                      rsp_result_code, rsp_probe_count);
               fail_count++;
            end else begin
               want = lookup_outcomes_q.pop_front();
               if (rsp_result_code !== want.code) begin
                  $error("result_code: expected %0d, actual %0d", want.code, rsp_result_code);
                  fail_count++;
               end
               if (rsp_probe_count !== want.probes) begin
                  $error("probe_count: expected %0d, actual %0d", want.probes, rsp_probe_count);
                  fail_count++;
               end
               codes_seen[rsp_result_code]++;
               results_checked++;
            end
         end
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // A correct run finishes well within this time limit, which ends the simulation as failed.
   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_FIND;
      req_symbols = '0;
      req_length = '0;
      req_idle_pct = 27;
      rsp_idle_pct = 27;
      rsp_hold_request = 1'b0;
      stored_count = 0;
      items_sent = 0;
      results_checked = 0;
      fail_count = 0;
      codes_seen = '{default: 0};
      foreach (dict_table[i]) dict_table[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].syms, DIRECTED_ROWS[i].len,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].probes);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 300) rsp_hold_request = 1'b1;
         if (i == 600) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (i == 800) begin
            req_idle_pct = 27;
            rsp_idle_pct = 27;
         end
         send_random_item();
      end
      req_valid <= 1'b0;

      while (lookup_outcomes_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("Checked %0d results from %0d items: %0d present, %0d absent,",
               results_checked, items_sent, codes_seen[RES_PRESENT], codes_seen[RES_ABSENT]);
      $display("%0d inserted, %0d full; the mirror ended with %0d of %0d slots occupied.",
               codes_seen[RES_INSERTED], codes_seen[RES_FULL], stored_count, TABLE_SIZE);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### dna_dictionary_double_hash_top.f
+incdir+hw/rtl
hw/rtl/dnadh_pkg.sv
hw/rtl/dnadh_ram.sv
hw/rtl/dnadh_hash.sv
hw/rtl/dna_dictionary_double_hash_top.sv
dv/dna_dictionary_double_hash_top_tb.sv
